// ===== sv/ewb_pkg.sv =====
// package for the exp-weighted 3x3 blur: shared types, register codes and constants
// no dependencies; imported by every module of the block
`default_nettype none

package ewb_pkg;

  // fixed field widths
  localparam int unsigned SMP_W     = 17;  // clamped sample, Q1.16
  localparam int unsigned IN_W      = 20;  // raw sample, signed Q3.16
  localparam int unsigned OUT_COL_W = 11;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned HGT_W     = 13;
  localparam int unsigned IMG_W_W   = 12;
  localparam int unsigned CH_CNT_W  = 3;
  localparam int unsigned WGT_W     = 17;
  localparam int unsigned RCP_W     = 25;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 25;
  localparam int unsigned NUM_OUT_CH = 4;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 96;

  // issue-to-writeback latency of the channel pipeline
  localparam int unsigned MAC_LAT = 4;

  localparam logic [SMP_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [RCP_W-1:0] RCP_MAX   = 25'd16777216;
  localparam logic [HGT_W-1:0] HGT_MIN   = 13'd3;
  localparam logic [HGT_W-1:0] HGT_MAX   = 13'd4096;

  // register reset values
  localparam logic [IMG_W_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
  localparam logic [HGT_W-1:0]    RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [CH_CNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;
  localparam logic [WGT_W-1:0]    RST_WEIGHT_EDGE   = 17'd65536;
  localparam logic [WGT_W-1:0]    RST_WEIGHT_CORNER = 17'd65536;
  localparam logic [RCP_W-1:0]    RST_NORM_RECIP    = 25'd1864135;

  typedef logic [SMP_W-1:0] smp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_WEIGHT_EDGE   = 3'd3,
    REG_WEIGHT_CORNER = 3'd4,
    REG_NORM_RECIP    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [IMG_W_W-1:0]  image_width;
    logic [HGT_W-1:0]    image_height;
    logic [CH_CNT_W-1:0] channel_count;
    logic [WGT_W-1:0]    weight_edge;
    logic [WGT_W-1:0]    weight_corner;
    logic [RCP_W-1:0]    norm_recip;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_LOAD
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;   // zero one line-store row
    logic accept;  // word taken, latch pixel and read line store
    logic shift;   // shift window, write line store back
    logic issue;   // start one channel in the pipeline
    logic load;    // move results into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic interior;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/exp_weighted_3x3_blur.sv =====
// top level of the exp-weighted 3x3 blur: configuration registers, controller and datapath
// depends on ewb_pkg, ewb_ctrl, ewb_dp (and through it ewb_mac)
`default_nettype none

// Raster-order 3x3 blur with software-supplied weights. Each input word is one pixel with four
// signed Q3.16 samples; every sample is clamped to [0,1] and kept in a line store that holds the
// two previous rows, MAX_WIDTH entries deep. Once the current pixel sits at column >= 2 and
// row >= 2, the pixel one row up and one column left is filtered: center weight 1, edge and corner
// weights from the registers, scaled by norm_recip, rounded to nearest and saturated at 1.0.
// Border pixels give no output word; tlast marks the last interior pixel of a frame. A word with
// tuser set starts a new frame at column 0, row 0, and the position also wraps by itself after
// image_width x image_height pixels, each clipped to its valid range.
// Timing: after reset the line store is zeroed one row per cycle, so the block takes no input until
// all MAX_WIDTH entries are cleared. After that a border pixel is accepted, then its line-store
// read-modify-write follows. An interior pixel is accepted and written to the line store, then the
// channels go one per cycle through a single 4-stage weighting and scaling pipeline, then the
// results move into the output register. That register holds a finished word while the next
// pixel is accepted; the block stalls only if a new result is ready before the previous word is
// taken. Registers may be written only while no pixel is being processed.

module exp_weighted_3x3_blur #(
  parameter int unsigned MAX_WIDTH    = 2048,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [ewb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ewb_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  // pixel input
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // sample_0, sample_1, sample_2, sample_3 (20 bits each, signed)
  input  wire logic [ewb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // frame_start
  input  wire logic                               s_axis_tuser,
  // filtered pixel output
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // out_col (11), out_row (12), result_0..result_3 (17 each), zero fill (5)
  output logic [ewb_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  // frame_end
  output logic                                    m_axis_tlast
);
  import ewb_pkg::*;

  localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cfg_t           cfg_q;
  cmd_t           cmd;
  sts_t           sts;
  logic [CHW-1:0] chan;

  // register file, each write takes the low bits of the data word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= RST_IMAGE_WIDTH;
      cfg_q.image_height  <= RST_IMAGE_HEIGHT;
      cfg_q.channel_count <= RST_CHANNEL_COUNT;
      cfg_q.weight_edge   <= RST_WEIGHT_EDGE;
      cfg_q.weight_corner <= RST_WEIGHT_CORNER;
      cfg_q.norm_recip    <= RST_NORM_RECIP;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i[HGT_W-1:0];
        REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[CH_CNT_W-1:0];
        REG_WEIGHT_EDGE:   cfg_q.weight_edge   <= cfg_data_i[WGT_W-1:0];
        REG_WEIGHT_CORNER: cfg_q.weight_corner <= cfg_data_i[WGT_W-1:0];
        REG_NORM_RECIP:    cfg_q.norm_recip    <= cfg_data_i[RCP_W-1:0];
        default:           cfg_q <= cfg_q;  // unmapped index, ignored
      endcase
    end
  end

  // sequencing: clear pass, accept, window update, channel issue, output hand-off
  ewb_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CHW          (CHW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .chan_o     (chan)
  );

  // storage and arithmetic
  ewb_dp #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .CHW          (CHW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .frame_start_i (s_axis_tuser),
    .samples_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .chan_i        (chan),
    .sts_o         (sts),
    .out_data_o    (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== sv/ewb_mac.sv =====
// per-channel arithmetic pipeline: weighted 3x3 sum, reciprocal scaling, rounding, saturation
// depends on ewb_pkg
`default_nettype none

module ewb_mac #(
  parameter int unsigned CHW = 2
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic [CHW-1:0]          in_chan_i,
  input  wire ewb_pkg::smp_t [2:0][2:0] win_i,   // [column][row]
  input  wire logic [ewb_pkg::WGT_W-1:0] we_i,
  input  wire logic [ewb_pkg::WGT_W-1:0] wc_i,
  input  wire logic [ewb_pkg::RCP_W-1:0] rc_i,
  output logic                         res_valid_o,
  output logic [CHW-1:0]               res_chan_o,
  output ewb_pkg::smp_t                res_o
);
  import ewb_pkg::*;

  localparam int unsigned SUM4_W = SMP_W + 2;
  localparam int unsigned PRD_W  = SUM4_W + WGT_W;
  localparam int unsigned ACC_W  = 36;
  localparam int unsigned HALF_W = ACC_W / 2;
  localparam int unsigned PP_W   = HALF_W + RCP_W;
  localparam int unsigned TOT_W  = 62;

  logic [3:0]          v_q;
  logic [CHW-1:0]      ch0_q, ch1_q, ch2_q, ch3_q;
  logic [SUM4_W-1:0]   edge_q, corner_q;
  smp_t                ctr0_q, ctr1_q;
  logic [PRD_W-1:0]    pe_q, pc_q;
  logic [ACC_W-1:0]    acc_q;
  logic [PP_W-1:0]     plo_q, phi_q;
  logic [TOT_W-1:0]    tot;
  logic [21:0]         rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // sums of the edge neighbours and of the corner neighbours
    edge_q   <= SUM4_W'(win_i[1][0]) + SUM4_W'(win_i[1][2])
              + SUM4_W'(win_i[0][1]) + SUM4_W'(win_i[2][1]);
    corner_q <= SUM4_W'(win_i[0][0]) + SUM4_W'(win_i[2][0])
              + SUM4_W'(win_i[0][2]) + SUM4_W'(win_i[2][2]);
    ctr0_q   <= win_i[1][1];
    ch0_q    <= in_chan_i;
    // weights
    pe_q     <= edge_q * we_i;
    pc_q     <= corner_q * wc_i;
    ctr1_q   <= ctr0_q;
    ch1_q    <= ch0_q;
    // Q4.32 weighted sum
    acc_q    <= ACC_W'({ctr1_q, 16'd0}) + ACC_W'(pe_q) + ACC_W'(pc_q);
    ch2_q    <= ch1_q;
    // reciprocal product split in two halves
    plo_q    <= acc_q[HALF_W-1:0] * rc_i;
    phi_q    <= acc_q[ACC_W-1:HALF_W] * rc_i;
    ch3_q    <= ch2_q;
  end

  // round half up at bit 40, saturate at one
  assign tot = TOT_W'(plo_q) + TOT_W'({phi_q, {HALF_W{1'b0}}}) + (TOT_W'(1) << 39);
  assign rnd = tot[TOT_W-1:40];

  assign res_o       = (rnd > 22'(ONE_Q16)) ? ONE_Q16 : rnd[SMP_W-1:0];
  assign res_valid_o = v_q[3];
  assign res_chan_o  = ch3_q;

endmodule

`default_nettype wire

// ===== sv/ewb_ctrl.sv =====
// controller of the blur: line-store clearing, word acceptance, channel issue, output hand-off
// depends on ewb_pkg
`default_nettype none

module ewb_ctrl #(
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned CHW          = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  wire logic           m_tready_i,
  input  wire ewb_pkg::sts_t  sts_i,
  output ewb_pkg::cmd_t       cmd_o,
  output logic [CHW-1:0]      chan_o
);
  import ewb_pkg::*;

  localparam int unsigned CALC_LEN = MAX_CHANNELS + MAC_LAT;
  localparam int unsigned CNT_W    = $clog2(CALC_LEN);

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovld_q, ovld_d;
  logic             calc_last, slot_free;

  assign calc_last = (cnt_q == CNT_W'(CALC_LEN - 1));
  assign slot_free = !ovld_q || m_tready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:  if (s_tvalid_i) state_d = ST_READ;
      ST_READ:  state_d = sts_i.interior ? ST_CALC : ST_IDLE;
      ST_CALC:  if (calc_last) state_d = ST_LOAD;
      ST_LOAD:  if (slot_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    cnt_d      = '0;
    ovld_d     = ovld_q && !m_tready_i;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        s_tready_o   = 1'b1;
        cmd_o.accept = s_tvalid_i;
      end
      ST_READ:  cmd_o.shift = 1'b1;
      ST_CALC: begin
        cmd_o.issue = (cnt_q < CNT_W'(MAX_CHANNELS));
        cnt_d       = calc_last ? '0 : cnt_q + 1'b1;
      end
      ST_LOAD: begin
        cmd_o.load = slot_free;
        if (slot_free) ovld_d = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign chan_o     = cnt_q[CHW-1:0];
  assign m_tvalid_o = ovld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ewb_dp.sv =====
// datapath of the blur: position counters, line store memory, 3x3 window, result and output registers
// depends on ewb_pkg and ewb_mac
`default_nettype none

module ewb_dp #(
  parameter int unsigned MAX_WIDTH    = 2048,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned CHW          = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ewb_pkg::cfg_t                     cfg_i,
  input  wire logic                              frame_start_i,
  input  wire logic [ewb_pkg::IN_DATA_W-1:0]     samples_i,
  input  wire ewb_pkg::cmd_t                     cmd_i,
  input  wire logic [CHW-1:0]                    chan_i,
  output ewb_pkg::sts_t                          sts_o,
  output logic [ewb_pkg::OUT_DATA_W-1:0]         out_data_o,
  output logic                                   out_last_o
);
  import ewb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
  localparam int unsigned LW = MAX_CHANNELS * SMP_W;

  // effective configuration
  logic [WW-1:0]       w_eff, w_raw;
  logic [HGT_W-1:0]    h_eff;
  logic [CH_CNT_W-1:0] nch;
  logic [WGT_W-1:0]    we, wc;
  logic [RCP_W-1:0]    rc;

  // position
  logic [CW-1:0]       cnt_col_q, cnt_col_d, col_cur, pos_col_q, col_m1;
  logic [ROW_W-1:0]    cnt_row_q, cnt_row_d, row_cur, pos_row_q;
  logic [WW-1:0]       col_inc;
  logic [HGT_W-1:0]    row_inc;
  logic                interior_q, fend_q;

  // line store, rows hold {upper, middle}
  logic [2*LW-1:0]     mem [MAX_WIDTH];
  logic [2*LW-1:0]     rd_q, mem_wdata;
  logic [CW-1:0]       mem_waddr, clr_q;
  logic                mem_we;
  logic [LW-1:0]       cur_q, cur_d;

  // window [column][row][channel], column 2 newest, row 2 current
  smp_t                win_q [3][3][MAX_CHANNELS];
  smp_t [2:0][2:0]     win_sel;

  // channel results
  logic                mres_valid;
  logic [CHW-1:0]      mres_chan;
  smp_t                mres;
  smp_t                res_q [MAX_CHANNELS];
  smp_t [NUM_OUT_CH-1:0] res_all;

  // output register
  logic [OUT_COL_W-1:0]  ocol_q;
  logic [ROW_W-1:0]      orow_q;
  smp_t [NUM_OUT_CH-1:0] ores_q;
  logic                  olast_q;

  always_comb begin
    w_raw = WW'(cfg_i.image_width);
    if (w_raw < WW'(3))              w_eff = WW'(3);
    else if (w_raw > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else                             w_eff = w_raw;
    if (cfg_i.image_height < HGT_MIN)      h_eff = HGT_MIN;
    else if (cfg_i.image_height > HGT_MAX) h_eff = HGT_MAX;
    else                                   h_eff = cfg_i.image_height;
    if (cfg_i.channel_count == '0)                          nch = CH_CNT_W'(1);
    else if (cfg_i.channel_count > CH_CNT_W'(MAX_CHANNELS)) nch = CH_CNT_W'(MAX_CHANNELS);
    else                                                    nch = cfg_i.channel_count;
    we = (cfg_i.weight_edge > ONE_Q16) ? ONE_Q16 : cfg_i.weight_edge;
    wc = (cfg_i.weight_corner > ONE_Q16) ? ONE_Q16 : cfg_i.weight_corner;
    rc = (cfg_i.norm_recip > RCP_MAX) ? RCP_MAX : cfg_i.norm_recip;
  end

  // position of the incoming pixel and of the next one
  always_comb begin
    if (frame_start_i || WW'(cnt_col_q) >= w_eff) col_cur = '0;
    else                                          col_cur = cnt_col_q;
    if (frame_start_i || HGT_W'(cnt_row_q) >= h_eff) row_cur = '0;
    else                                             row_cur = cnt_row_q;
    col_inc = WW'(col_cur) + 1'b1;
    row_inc = HGT_W'(row_cur) + 1'b1;
    if (col_inc >= w_eff) begin
      cnt_col_d = '0;
      cnt_row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      cnt_col_d = col_inc[CW-1:0];
      cnt_row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_col_q  <= '0;
      cnt_row_q  <= '0;
      clr_q      <= '0;
      interior_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        cnt_col_q  <= cnt_col_d;
        cnt_row_q  <= cnt_row_d;
        interior_q <= (col_cur >= CW'(2)) && (row_cur >= ROW_W'(2));
      end
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
    end
  end

  // clamp each sample to [0,1]
  always_comb begin
    logic [IN_W-1:0] raw;
    cur_d = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      raw = samples_i[c*IN_W +: IN_W];
      if (raw[IN_W-1])                  cur_d[c*SMP_W +: SMP_W] = '0;
      else if (raw > IN_W'(ONE_Q16))    cur_d[c*SMP_W +: SMP_W] = ONE_Q16;
      else                              cur_d[c*SMP_W +: SMP_W] = raw[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q     <= cur_d;
      pos_col_q <= col_cur;
      pos_row_q <= row_cur;
      fend_q    <= (col_inc == w_eff) && (row_inc == h_eff);
    end
  end

  // line store: middle row moves up, current pixel becomes middle
  assign mem_we    = cmd_i.clear || cmd_i.shift;
  assign mem_waddr = cmd_i.clear ? clr_q : pos_col_q;
  assign mem_wdata = cmd_i.clear ? '0 : {rd_q[LW-1:0], cur_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.accept) rd_q <= mem[col_cur];
  end

  assign sts_o.clear_last = (clr_q == CW'(MAX_WIDTH - 1));
  assign sts_o.interior   = interior_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[0][r][c] <= win_q[1][r][c];
          win_q[1][r][c] <= win_q[2][r][c];
        end
        win_q[2][0][c] <= rd_q[LW + c*SMP_W +: SMP_W];
        win_q[2][1][c] <= rd_q[c*SMP_W +: SMP_W];
        win_q[2][2][c] <= cur_q[c*SMP_W +: SMP_W];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        win_sel[k][r] = win_q[k][r][chan_i];
      end
    end
  end

  ewb_mac #(
    .CHW (CHW)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.issue),
    .in_chan_i   (chan_i),
    .win_i       (win_sel),
    .we_i        (we),
    .wc_i        (wc),
    .rc_i        (rc),
    .res_valid_o (mres_valid),
    .res_chan_o  (mres_chan),
    .res_o       (mres)
  );

  // channels past the used count read zero
  always_ff @(posedge clk_i) begin
    if (mres_valid) begin
      res_q[mres_chan] <= (CH_CNT_W'(mres_chan) < nch) ? mres : '0;
    end
  end

  always_comb begin
    res_all = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      res_all[c] = res_q[c];
    end
  end

  assign col_m1 = pos_col_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ocol_q  <= OUT_COL_W'(col_m1);
      orow_q  <= pos_row_q - 1'b1;
      ores_q  <= res_all;
      olast_q <= fend_q;
    end
  end

  assign out_data_o = {5'd0, ores_q[3], ores_q[2], ores_q[1], ores_q[0], orow_q, ocol_q};
  assign out_last_o = olast_q;

endmodule

`default_nettype wire

// ===== dv/ewb_checker.sv =====
// checker for the exp-weighted 3x3 blur: watches the config port and both streams,
// predicts every filtered word and compares it field by field
// depends on ewb_pkg only
module ewb_blur_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ewb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ewb_pkg::CFG_DAT_W-1:0]    cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  // sample_0, sample_1, sample_2, sample_3 (20 bits each, signed)
  input  wire logic [ewb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // frame_start
  input  wire logic                             s_axis_tuser,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // out_col (11), out_row (12), result_0..result_3 (17 each), zero fill (5)
  input  wire logic [ewb_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // frame_end
  input  wire logic                             m_axis_tlast,
  output int                                    fail_cnt_o,
  output int                                    pending_o,
  output int                                    checked_o
);
  import ewb_pkg::*;

  localparam int unsigned LINE_W     = 2048;
  localparam int unsigned CH_N       = 4;
  localparam int unsigned LINE_DEPTH = LINE_W * CH_N;
  localparam int unsigned RES_LSB    = OUT_COL_W + ROW_W;

  typedef struct packed {
    logic [OUT_COL_W-1:0]             col;
    logic [ROW_W-1:0]                 row;
    logic [NUM_OUT_CH-1:0][SMP_W-1:0] res;
    logic                             last;
  } blur_word_t;

  logic [IMG_W_W-1:0]  cfg_width;
  logic [HGT_W-1:0]    cfg_height;
  logic [CH_CNT_W-1:0] cfg_chans;
  logic [WGT_W-1:0]    cfg_edge;
  logic [WGT_W-1:0]    cfg_corner;
  logic [RCP_W-1:0]    cfg_recip;

  smp_t upper_row  [LINE_DEPTH];
  smp_t middle_row [LINE_DEPTH];
  smp_t win [3][3][CH_N];  // [column][row][channel], column 2 newest, row 2 current
  int unsigned next_col, next_row;

  blur_word_t filtered_q[$];
  int fails = 0;
  int checked = 0;

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // negative goes to zero, anything above 1.0 to 1.0
  function automatic smp_t clamp_raw(logic [IN_W-1:0] raw);
    if (raw[IN_W-1]) return '0;
    return (raw > IN_W'(ONE_Q16)) ? ONE_Q16 : raw[SMP_W-1:0];
  endfunction

  task automatic note_failure(input string msg);
    fails++;
    if (fails <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic filter_pixel(input logic fs, input logic [IN_DATA_W-1:0] d);
    int unsigned w_eff, h_eff, nch, col, row, idx, c, k;
    longint unsigned we_e, wc_e, rc_e, edges, corners, acc, r;
    smp_t cur;
    blur_word_t wd;
    w_eff = clip(cfg_width, 3, LINE_W);
    h_eff = clip(cfg_height, 3, HGT_MAX);
    nch   = clip(cfg_chans, 1, CH_N);
    we_e  = clip(cfg_edge, 0, ONE_Q16);
    wc_e  = clip(cfg_corner, 0, ONE_Q16);
    rc_e  = clip(cfg_recip, 0, RCP_MAX);
    if (fs) begin
      next_col = 0;
      next_row = 0;
    end
    if (next_col >= w_eff) next_col = 0;
    if (next_row >= h_eff) next_row = 0;
    col = next_col;
    row = next_row;

    for (c = 0; c < CH_N; c++) begin
      idx = (col * CH_N + c) % LINE_DEPTH;
      cur = clamp_raw(d[c*IN_W +: IN_W]);
      for (k = 0; k < 3; k++) begin
        win[0][k][c] = win[1][k][c];
        win[1][k][c] = win[2][k][c];
      end
      win[2][0][c] = upper_row[idx];
      win[2][1][c] = middle_row[idx];
      win[2][2][c] = cur;
      upper_row[idx]  = middle_row[idx];
      middle_row[idx] = cur;
    end

    // pixel one up and one left is interior
    if (col >= 2 && row >= 2) begin
      wd.col = OUT_COL_W'(col - 1);
      wd.row = ROW_W'(row - 1);
      for (c = 0; c < NUM_OUT_CH; c++) begin
        r = 0;
        if (c < nch) begin
          edges   = 64'(win[1][0][c]) + win[1][2][c] + win[0][1][c] + win[2][1][c];
          corners = 64'(win[0][0][c]) + win[2][0][c] + win[0][2][c] + win[2][2][c];
          acc = 64'(win[1][1][c]) * 64'(ONE_Q16) + edges * we_e + corners * wc_e;
          r = (acc * rc_e + (64'd1 << 39)) >> 40;
          if (r > ONE_Q16) r = ONE_Q16;
        end
        wd.res[c] = SMP_W'(r);
      end
      wd.last = (col == w_eff - 1) && (row == h_eff - 1);
      filtered_q.push_back(wd);
    end

    if (col + 1 >= w_eff) begin
      next_col = 0;
      next_row = (row + 1 >= h_eff) ? 0 : row + 1;
    end else begin
      next_col = col + 1;
    end
  endtask

  task automatic check_word(input logic [OUT_DATA_W-1:0] data, input logic last);
    blur_word_t want;
    logic [SMP_W-1:0] got;
    int unsigned c;
    if (filtered_q.size() == 0) begin
      note_failure($sformatf("word col %0d row %0d with nothing pending",
                             data[OUT_COL_W-1:0], data[OUT_COL_W +: ROW_W]));
      return;
    end
    want = filtered_q.pop_front();
    checked++;
    if (data[OUT_COL_W-1:0] !== want.col)
      note_failure($sformatf("out_col %0d, want %0d", data[OUT_COL_W-1:0], want.col));
    if (data[OUT_COL_W +: ROW_W] !== want.row)
      note_failure($sformatf("out_row %0d, want %0d", data[OUT_COL_W +: ROW_W], want.row));
    for (c = 0; c < NUM_OUT_CH; c++) begin
      got = data[RES_LSB + c*SMP_W +: SMP_W];
      if (got !== want.res[c])
        note_failure($sformatf("result_%0d %0d, want %0d at col %0d row %0d",
                               c, got, want.res[c], want.col, want.row));
    end
    if (last !== want.last)
      note_failure($sformatf("frame_end %b, want %b at col %0d row %0d",
                             last, want.last, want.col, want.row));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width  = RST_IMAGE_WIDTH;
      cfg_height = RST_IMAGE_HEIGHT;
      cfg_chans  = RST_CHANNEL_COUNT;
      cfg_edge   = RST_WEIGHT_EDGE;
      cfg_corner = RST_WEIGHT_CORNER;
      cfg_recip  = RST_NORM_RECIP;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int c = 0; c < CH_N; c++) win[i][j][c] = '0;
      next_col = 0;
      next_row = 0;
      filtered_q.delete();
    end else begin
      // outgoing word first: an expectation made at this edge cannot leave yet
      if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata, m_axis_tlast);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_IMAGE_WIDTH:   cfg_width  = cfg_data_i[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT:  cfg_height = cfg_data_i[HGT_W-1:0];
          REG_CHANNEL_COUNT: cfg_chans  = cfg_data_i[CH_CNT_W-1:0];
          REG_WEIGHT_EDGE:   cfg_edge   = cfg_data_i[WGT_W-1:0];
          REG_WEIGHT_CORNER: cfg_corner = cfg_data_i[WGT_W-1:0];
          REG_NORM_RECIP:    cfg_recip  = cfg_data_i[RCP_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) filter_pixel(s_axis_tuser, s_axis_tdata);
    end
    fail_cnt_o <= fails;
    pending_o  <= filtered_q.size();
    checked_o  <= checked;
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the exp-weighted 3x3 blur: clock, reset, register writes and pixel stimulus
// depends on ewb_pkg, exp_weighted_3x3_blur and the ewb_blur_checker beside it
module tb_top;
  import ewb_pkg::*;

  // room for about 700 pixels plus idling, stalls, register writes, drains and the line-store
  // clear after reset, with a wide margin
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  // wait well past the processing of an interior pixel before touching registers
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_PIXELS  = 48;
  // partial runs under out-of-range width and height settings
  localparam int unsigned WIDE_RUN_PIXELS = 48;
  localparam int unsigned TALL_RUN_PIXELS = 60;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DAT_W-1:0]  cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // sample_0..sample_3, 20 bits each
  logic                  s_axis_tuser  = 1'b0; // frame_start
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // out_col, out_row, result_0..result_3
  logic                  m_axis_tlast;        // frame_end

  int fail_count;
  int pending_words;
  int checked_words;

  int unsigned cycle_cnt     = 0;
  int unsigned pixels_sent   = 0;
  int unsigned settings_used = 0;
  int unsigned frame_pixels  = 0;  // pixels in one frame under the current setting
  int unsigned idle_pct      = 0;  // sender idle chance per cycle, percent
  int unsigned stall_pct     = 0;  // receiver stall chance per cycle, percent

  exp_weighted_3x3_blur u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ewb_blur_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_cnt_o    (fail_count),
    .pending_o     (pending_words),
    .checked_o     (checked_words)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver back-pressure, one fresh draw per cycle
  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_cnt, pending_words);
      $display("exp_weighted_3x3_blur: mismatch");
      $finish;
    end
  end

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Q1.24 reciprocal of 1 + 4*edge + 4*corner, weights saturated at 1.0 first
  function automatic int unsigned recip_for(int unsigned edge_w, int unsigned corner_w);
    longint unsigned total;
    total = 65536 + 4 * clip(edge_w, 0, 65536) + 4 * clip(corner_w, 0, 65536);
    return int'((64'd1 << 40) / total);
  endfunction

  // corner values of a signed Q3.16 sample
  function automatic logic [IN_W-1:0] extreme_sample(int unsigned k);
    case (k % 7)
      0:       return 20'h80000;  // most negative
      1:       return 20'h7FFFF;  // most positive
      2:       return 20'h00000;
      3:       return 20'h10000;  // exactly 1.0
      4:       return 20'h10001;  // just above 1.0
      5:       return 20'hFFFFF;  // -1 lsb
      default: return 20'h00001;
    endcase
  endfunction

  // mostly in [0,1], some just above 1.0, some full-range raw values so every bit toggles, some corners
  function automatic logic [IN_W-1:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return IN_W'($urandom_range(65536));
    if (sel < 72) return IN_W'($urandom);
    if (sel < 82) return IN_W'($urandom_range(70000, 65537));
    return extreme_sample($urandom_range(6));
  endfunction

  function automatic logic [IN_DATA_W-1:0] rand_pixel();
    return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
  endfunction

  // register write, then the enable goes low again so consecutive writes never collide
  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DAT_W'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // program all six registers and pick the idling mode for the next stretch:
  // 0 none, 1 sender idle, 2 receiver stalls, 3 both a little
  task automatic apply_settings(input int unsigned w, input int unsigned h, input int unsigned ch,
                                input int unsigned edge_w, input int unsigned corner_w,
                                input int unsigned recip, input int unsigned mode);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, ch);
    write_reg(REG_WEIGHT_EDGE, edge_w);
    write_reg(REG_WEIGHT_CORNER, corner_w);
    write_reg(REG_NORM_RECIP, recip);
    frame_pixels = clip(w % 4096, 3, 2048) * clip(h % 8192, 3, 4096);
    settings_used++;
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 63; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 63; end
      default: begin idle_pct = 17; stall_pct = 17; end
    endcase
  endtask

  // one word on the pixel input; valid stays up after acceptance so back-to-back
  // words never see valid dropped and raised in the same step
  task automatic push_pixel(input logic fs, input logic [IN_DATA_W-1:0] d);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
  endtask

  task automatic send_frame(input int unsigned npix, input logic fs_first);
    for (int unsigned i = 0; i < npix; i++) push_pixel((i == 0) ? fs_first : 1'b0, rand_pixel());
  endtask

  // stop sending until every filtered word is back, then let the block go quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned i, p, w, h, ch, ew, cw, rc, phase_start;
    bit held;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: smallest frame, four channels, full weights and saturated reciprocal
    // so sums above one clip at 1.0; samples walk through the corner values
    apply_settings(3, 3, 4, 65536, 65536, RCP_MAX, 0);
    for (i = 0; i < 9; i++)
      push_pixel(i == 0, {extreme_sample(i + 9), extreme_sample(i + 6),
                          extreme_sample(i + 3), extreme_sample(i)});
    // second frame with no frame start: position must wrap by itself
    for (i = 0; i < 9; i++)
      push_pixel(1'b0, {extreme_sample(2*i + 3), extreme_sample(2*i + 2),
                        extreme_sample(2*i + 1), extreme_sample(2*i)});
    // partial frame, then a frame start in the middle of it
    for (i = 0; i < 7; i++) push_pixel(i == 4, rand_pixel());
    drain();

    // width, height and channel count below their range: width/height act as 3, one channel,
    // center-only weighting, reciprocal above range saturates at 1.0
    apply_settings(0, 0, 0, 0, 0, 32'h1FF_FFFF, 1);
    repeat (3) send_frame(frame_pixels, 1'b1);
    drain();

    // two channels (upper results fixed at zero), edge weight above range, wrapping frames
    apply_settings(5, 4, 2, 131071, 1000, recip_for(131071, 1000), 2);
    send_frame(frame_pixels, 1'b1);
    send_frame(frame_pixels, 1'b0);
    send_frame(frame_pixels, 1'b0);
    drain();

    // width register above range: a partial first row, the column must not wrap early
    apply_settings(4095, 3, 4, 65536, 65536, RST_NORM_RECIP, 0);
    send_frame(WIDE_RUN_PIXELS, 1'b1);
    drain();

    // height register above range and channel count above range: the first rows of a
    // tall frame, the row must not wrap early
    apply_settings(3, 8191, 5, 40000, 20000, recip_for(40000, 20000), 0);
    send_frame(TALL_RUN_PIXELS, 1'b1);
    drain();

    // random part: small frames, random registers, idling modes in turn
    for (p = 0; p < RANDOM_PHASES; p++) begin
      w  = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(9, 3);
      h  = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(7, 3);
      ch = $urandom_range(7);
      ew = ($urandom_range(7) == 0) ? $urandom_range(131071, 65537) : $urandom_range(65536);
      cw = ($urandom_range(7) == 0) ? $urandom_range(131071, 65537) : $urandom_range(65536);
      rc = ($urandom_range(4) == 0) ? $urandom_range(32'h1FF_FFFF) : recip_for(ew, cw);
      apply_settings(w, h, ch, ew, cw, rc, p % 4);
      phase_start = pixels_sent;
      held = 1'b0;
      while (pixels_sent - phase_start < PHASE_PIXELS) begin
        if ($urandom_range(4) != 0) begin
          // well-formed frame, sometimes relying on the wrap instead of a frame start
          send_frame(frame_pixels, $urandom_range(5) != 0);
        end else begin
          // noise: short bursts with frame starts landing anywhere
          repeat ($urandom_range(8, 1)) push_pixel($urandom_range(3) == 0, rand_pixel());
        end
        if (!held && pixels_sent - phase_start >= PHASE_PIXELS / 2) begin
          drain();
          held = 1'b1;
        end
      end
      drain();
    end

    $display("sent %0d pixels under %0d register settings, %0d filtered words compared",
             pixels_sent, settings_used, checked_words);
    $display("small frames up to 9x7 plus partial runs at out-of-range width and height, all idling modes");
    if (fail_count == 0) begin
      $display("exp_weighted_3x3_blur: match");
    end else begin
      $display("exp_weighted_3x3_blur: mismatch");
    end
    $finish;
  end

endmodule
